>>> src/kfas_pkg.sv
package kfas_pkg;

  // Defaults and fixed field widths
  localparam int MAX_KEYS_DEF = 64;
  localparam int NUM_COMP     = 3;
  localparam int COMP_W       = 32;
  localparam int VEC_W        = NUM_COMP * COMP_W;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  // One in Q16.16
  localparam logic [16:0] Q_ONE = 17'd65536;

  // Input item actions
  localparam logic [1:0] ACT_LOAD_KEY = 2'd0;
  localparam logic [1:0] ACT_LOAD_IN  = 2'd1;
  localparam logic [1:0] ACT_LOAD_OUT = 2'd2;
  localparam logic [1:0] ACT_QUERY    = 2'd3;

  // Interpolation modes
  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCHK,
    ST_BSET,
    ST_FRD,
    ST_SETUP,
    ST_DIV,
    ST_LIN,
    ST_HPOW,
    ST_HCOMP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_HINT,
    PH_NEXT,
    PH_SEARCH
  } phase_t;

  // Saturate to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/keyframe_animation_sampler_core.sv
// Keyframe animation sampler.
// Input channel (in_valid/in_stall): actions 0..2 load a key time and value,
// an in-tangent or an out-tangent at key_index and give no
// result; action 3 queries time_value and gives one result on the output
// channel (out_valid/out_stall) with the interpolated vector, the segment
// used and an out-of-range flag.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 sets the
// interpolation mode, index 1 the key count; write only while idle.
// A query probes the hinted and then the next segment, then runs up to
// log2(MAX_KEYS) binary-search probes; if no segment holds the time it falls
// back to segment 0 with the out-of-range flag. A setup step follows, then a
// bit-serial divider for the segment fraction (skipped once it plainly exceeds
// one), then linear or cubic interpolation with the three components taken in
// turn; step mode, or a segment of no length, gives the start key value.
// The input stalls while a query is at work.
// A finished result sits in the output register; the next item is taken
// while it waits, and a following query holds in its last cycle until the
// register frees.
// Reset clears the mode to linear, the key count to 2 and the segment hint;
// key memories are undefined until loaded.
module keyframe_animation_sampler_core #(
  parameter int MAX_KEYS = kfas_pkg::MAX_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [5:0]                       key_index,
  input  logic [31:0]                      time_value,
  input  logic signed [31:0]               vec_x,
  input  logic signed [31:0]               vec_y,
  input  logic signed [31:0]               vec_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               result_x,
  output logic signed [31:0]               result_y,
  output logic signed [31:0]               result_z,
  output logic [5:0]                       segment_index,
  output logic                             out_of_range,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kfas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kfas_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kfas_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = $clog2(MAX_KEYS + 1);

  // Key memories
  logic [31:0]    key_times    [MAX_KEYS];
  logic [VEC_W-1:0] key_values [MAX_KEYS];
  logic [VEC_W-1:0] in_tangents [MAX_KEYS];
  logic [VEC_W-1:0] out_tangents [MAX_KEYS];

  logic [31:0]      ta, tb;
  logic [VEC_W-1:0] v0w, v1w, otw, itw;

  // Control state
  state_t         state, state_next;
  phase_t         phase;
  logic [1:0]     interp_mode;
  logic [6:0]     key_count;
  logic [AW-1:0]  last_segment;
  logic [AW-1:0]  probe, probe_p1;
  logic [NW-1:0]  nkeys, lo, hi, mid, n_cur;
  logic [4:0]     cnt;
  logic [2:0]     step;
  logic [1:0]     comp;

  // Datapath registers
  logic [31:0]    tq, lenr, dr, rem;
  logic [16:0]    q, u, t2, t3;
  logic           flag;
  logic [VEC_W-1:0] res;
  logic signed [65:0] prod;
  logic signed [68:0] pb;
  logic signed [70:0] acc;
  logic signed [48:0] m0, m1;
  logic signed [19:0] h00, h10, h01, h11;

  logic           in_acc, is_query, load_ok, out_load;
  logic           hit, hint_ok, next_ok, interp, sat_u;
  logic [31:0]    d_c, len_c;
  logic [32:0]    trial;
  logic           ge;
  logic [16:0]    qn;
  logic [31:0]    v0c, v1c, otc, itc;
  logic signed [32:0] len33, dd;
  logic signed [19:0] t1e, t2e, t3e;
  logic signed [49:0] lin_sum;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign is_query  = (action == ACT_QUERY);
  assign load_ok   = (32'(key_index) < 32'(MAX_KEYS));

  // Clamp the key count to between 2 and the table size
  always_comb begin
    if (key_count < 7'd2) begin
      n_cur = NW'(2);
    end else if (32'(key_count) > 32'(MAX_KEYS)) begin
      n_cur = NW'(MAX_KEYS);
    end else begin
      n_cur = NW'(key_count);
    end
  end

  assign probe_p1 = (probe == AW'(MAX_KEYS - 1)) ? probe : probe + 1'b1;
  assign mid      = lo + ((hi - lo) >> 1);
  assign hit      = (tq >= ta) && (tq <= tb);
  assign hint_ok  = (NW'(last_segment) < (n_cur - 1'b1));
  assign next_ok  = ((NW'(probe) + 1'b1) < (nkeys - 1'b1));

  // Segment setup
  assign d_c    = (tq > ta) ? (tq - ta) : 32'd0;
  assign len_c  = tb - ta;
  assign interp = ((interp_mode == MODE_LINEAR) || (interp_mode == MODE_CUBIC)) &&
                  (tb > ta);
  assign sat_u  = ({1'b0, d_c} >= {len_c, 1'b0});

  // Divider step
  assign trial = {rem, (cnt == 5'd16) ? dr[0] : 1'b0};
  assign ge    = (trial >= {1'b0, lenr});
  assign qn    = {q[15:0], ge};

  // Component operands
  assign v0c   = v0w[32*comp +: 32];
  assign v1c   = v1w[32*comp +: 32];
  assign otc   = otw[32*comp +: 32];
  assign itc   = itw[32*comp +: 32];
  assign len33 = $signed({1'b0, lenr});
  assign dd    = $signed({v1c[31], v1c}) - $signed({v0c[31], v0c});
  assign lin_sum = $signed({{18{v0c[31]}}, v0c}) + $signed(prod[65:16]);
  assign t1e   = $signed({3'b000, u});
  assign t2e   = $signed({3'b000, t2});
  assign t3e   = $signed({3'b000, t3});

  // Memory write and read ports
  always_ff @(posedge clk) begin
    if (in_acc && !is_query && load_ok) begin
      if (action == ACT_LOAD_KEY) begin
        key_times[AW'(key_index)]  <= time_value;
        key_values[AW'(key_index)] <= {vec_z, vec_y, vec_x};
      end else if (action == ACT_LOAD_IN) begin
        in_tangents[AW'(key_index)] <= {vec_z, vec_y, vec_x};
      end else begin
        out_tangents[AW'(key_index)] <= {vec_z, vec_y, vec_x};
      end
    end
    ta  <= key_times[probe];
    tb  <= key_times[probe_p1];
    v0w <= key_values[probe];
    v1w <= key_values[probe_p1];
    otw <= out_tangents[probe];
    itw <= in_tangents[probe_p1];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_next = hint_ok ? ST_SRD : ST_BSET;
        end
      end
      ST_SRD: state_next = ST_SCHK;
      ST_SCHK: begin
        if (hit) begin
          state_next = ST_SETUP;
        end else begin
          priority case (phase)
            PH_HINT:   state_next = next_ok ? ST_SRD : ST_BSET;
            PH_NEXT:   state_next = ST_BSET;
            default: begin
              state_next = ((ta > tq) && (probe == '0)) ? ST_FRD : ST_BSET;
            end
          endcase
        end
      end
      ST_BSET:  state_next = (lo <= hi) ? ST_SRD : ST_FRD;
      ST_FRD:   state_next = ST_SETUP;
      ST_SETUP: begin
        if (!interp) begin
          state_next = ST_DONE;
        end else if (sat_u) begin
          state_next = (interp_mode == MODE_LINEAR) ? ST_LIN : ST_HPOW;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == 5'd0) begin
          state_next = (interp_mode == MODE_LINEAR) ? ST_LIN : ST_HPOW;
        end
      end
      ST_LIN: begin
        if (step[0] && comp == 2'(NUM_COMP - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_HPOW: begin
        if (step == 3'd4) begin
          state_next = ST_HCOMP;
        end
      end
      ST_HCOMP: begin
        if (step == 3'd7 && comp == 2'(NUM_COMP - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    out_load = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      interp_mode  <= MODE_LINEAR;
      key_count    <= 7'd2;
      last_segment <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_INTERP_MODE) begin
          interp_mode <= cfg_data[1:0];
        end else if (cfg_index == CFG_KEY_COUNT) begin
          key_count <= cfg_data;
        end
      end
      // remember the hit segment, drop the hint on a miss
      if (state == ST_SCHK && hit) begin
        last_segment <= probe;
      end else if (state_next == ST_FRD && state != ST_FRD) begin
        last_segment <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search and arithmetic datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        tq    <= time_value;
        nkeys <= n_cur;
        lo    <= '0;
        hi    <= n_cur - NW'(2);
        probe <= last_segment;
        phase <= PH_HINT;
        flag  <= 1'b0;
      end
      ST_SRD: ;
      ST_SCHK: begin
        if (!hit) begin
          priority case (phase)
            PH_HINT: begin
              if (next_ok) begin
                probe <= probe_p1;
                phase <= PH_NEXT;
              end
            end
            PH_NEXT: ;
            default: begin
              if (ta > tq) begin
                if (probe == '0) begin
                  flag <= 1'b1;
                end else begin
                  hi <= NW'(probe) - 1'b1;
                end
              end else begin
                lo <= NW'(probe) + 1'b1;
              end
            end
          endcase
        end
      end
      ST_BSET: begin
        if (lo <= hi) begin
          probe <= AW'(mid);
          phase <= PH_SEARCH;
        end else begin
          probe <= '0;
          flag  <= 1'b1;
        end
      end
      ST_FRD: ;
      ST_SETUP: begin
        lenr <= len_c;
        dr   <= d_c;
        rem  <= {1'b0, d_c[31:1]};
        cnt  <= 5'd16;
        q    <= '0;
        comp <= '0;
        step <= '0;
        res  <= v0w;
        if (interp && sat_u) begin
          u    <= Q_ONE;
          flag <= 1'b1;
        end
      end
      ST_DIV: begin
        rem <= ge ? 32'(trial - {1'b0, lenr}) : trial[31:0];
        q   <= qn;
        cnt <= cnt - 1'b1;
        if (cnt == 5'd0) begin
          if (qn > Q_ONE) begin
            u    <= Q_ONE;
            flag <= 1'b1;
          end else begin
            u <= qn;
          end
        end
      end
      ST_LIN: begin
        if (!step[0]) begin
          prod <= dd * $signed({16'd0, u});
          step <= 3'd1;
        end else begin
          res[32*comp +: 32] <= sat32({{14{lin_sum[49]}}, lin_sum});
          comp <= comp + 1'b1;
          step <= 3'd0;
        end
      end
      ST_HPOW: begin
        unique case (step)
          3'd0: prod <= $signed({16'd0, u}) * $signed({16'd0, u});
          3'd1: t2 <= prod[32:16];
          3'd2: prod <= $signed({16'd0, t2}) * $signed({16'd0, u});
          3'd3: t3 <= prod[32:16];
          default: begin
            h00 <= (t3e <<< 1) - (t2e + (t2e <<< 1)) + 20'sd65536;
            h10 <= t3e - (t2e <<< 1) + t1e;
            h01 <= (t2e + (t2e <<< 1)) - (t3e <<< 1);
            h11 <= t3e - t2e;
          end
        endcase
        step <= (step == 3'd4) ? 3'd0 : step + 1'b1;
      end
      ST_HCOMP: begin
        unique case (step)
          3'd0: prod <= len33 * $signed({otc[31], otc});
          3'd1: begin
            m0   <= prod[64:16];
            prod <= len33 * $signed({itc[31], itc});
          end
          3'd2: begin
            m1 <= prod[64:16];
            pb <= h00 * $signed({{17{v0c[31]}}, v0c});
          end
          3'd3: begin
            acc <= 71'(pb);
            pb  <= h10 * m0;
          end
          3'd4: begin
            acc <= acc + pb;
            pb  <= h01 * $signed({{17{v1c[31]}}, v1c});
          end
          3'd5: begin
            acc <= acc + pb;
            pb  <= h11 * m1;
          end
          3'd6: acc <= acc + pb;
          default: begin
            res[32*comp +: 32] <= sat32({{9{acc[70]}}, acc[70:16]});
            comp <= comp + 1'b1;
          end
        endcase
        step <= step + 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_x      <= res[31:0];
      result_y      <= res[63:32];
      result_z      <= res[95:64];
      segment_index <= 6'(probe);
      out_of_range  <= flag;
    end
  end

endmodule
